// ===== hw/rtl/spq_pkg.sv =====
// Shared types and constants for the stable priority queue.
`default_nettype none

package spq_pkg;

    // Number of cells in the chain
    localparam int CAPACITY = 16;
    // Width of the held-entry count (holds 0..CAPACITY)
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths fixed by the interface
    localparam int VAL_W    = 32;
    localparam int PRI_W    = 16;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int OCNT_W   = 5;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;

    // Command codes on the input stream
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SERVE  = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    // Status codes on the output stream
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_SHIFT
    } t_op;

    // One stored pair
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic        [PRI_W-1:0] prio;
    } t_entry;

    // Broadcast control to the chain
    typedef struct packed {
        t_op                     op;
        logic signed [VAL_W-1:0] value;
        logic        [PRI_W-1:0] prio;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
// One cell of the sorted chain: holds a pair, compares it, and shifts with its neighbors.
`default_nettype none

module spq_cell (
    input  wire logic               i_clk,
    input  wire spq_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_valid,      // cell holds a live entry
    input  wire logic               i_shift,      // take the right neighbor's entry
    input  wire logic               i_left_keep,  // left neighbor keeps its entry on insert
    input  wire spq_pkg::t_entry    i_left_entry,
    input  wire spq_pkg::t_entry    i_right_entry,
    output spq_pkg::t_entry         o_entry,
    output logic                    o_keep,
    output logic                    o_match
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Ordering and search compares
    assign o_keep  = i_valid && (r_entry.prio >= i_ctl.prio);
    assign o_match = i_valid && (r_entry.value == i_ctl.value);
    assign o_entry = r_entry;

    // Next content: hold, take the new pair, or shift from a neighbor
    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.op)
            OP_INSERT: begin
                if (!o_keep) begin
                    if (i_left_keep) begin
                        n_entry.value = i_ctl.value;
                        n_entry.prio  = i_ctl.prio;
                    end else begin
                        n_entry = i_left_entry;
                    end
                end
            end
            OP_SHIFT: begin
                if (i_shift) begin
                    n_entry = i_right_entry;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    // Payload storage, no reset needed
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stable_priority_queue_unit.sv =====
// Top level of the stable priority queue: command decode, cell chain and output register.
`default_nettype none

// Stable priority queue built as a chain of CAPACITY cells kept sorted highest
// priority first, equal priorities in arrival order. Commands: insert, serve
// front, remove first entry matching a value. Every command yields exactly one
// result (status, taken pair, count after the command). All cells compare and
// shift together in the cycle a command is accepted, so a command is accepted
// every clock cycle as long as the output side keeps taking results; the
// result appears in the output register in the cycle after acceptance. The
// output register decouples the two sides: a new command is taken whenever the
// register is empty or its result is taken in the same cycle.
module stable_priority_queue_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    // [1:0] command, [33:2] item_value, [49:34] item_priority, rest zero
    input  wire logic [spq_pkg::S_DATA_W-1:0] i_s_tdata,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    // [1:0] status, [33:2] taken_value, [49:34] taken_priority,
    // [54:50] entry_count, rest zero
    output logic [spq_pkg::M_DATA_W-1:0]      o_m_tdata
);
    import spq_pkg::*;

    logic                    w_accept;
    t_cmd                    w_cmd;
    logic signed [VAL_W-1:0] w_value;
    logic        [PRI_W-1:0] w_priority;

    t_entry                  w_entry [CAPACITY];
    logic [CAPACITY-1:0]     w_keep;
    logic [CAPACITY-1:0]     w_match;
    logic [CAPACITY-1:0]     w_valid;
    logic [CAPACITY-1:0]     w_after;    // cells at or past the first match
    logic [CAPACITY-1:0]     w_first;    // one-hot first match
    logic [CAPACITY-1:0]     w_shift;
    logic                    w_empty;
    logic                    w_full;
    logic                    w_found;
    t_entry                  w_hit;
    t_cell_ctl               w_ctl;

    t_status                 w_status;
    logic signed [VAL_W-1:0] w_tvalue;
    logic        [PRI_W-1:0] w_tpri;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_m_valid;
    logic [M_DATA_W-1:0]     r_m_data;
    logic [M_DATA_W-1:0]     n_m_data;

    // Handshake
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // Unpack the command transaction
    assign w_cmd      = t_cmd'(i_s_tdata[CMD_W-1:0]);
    assign w_value    = $signed(i_s_tdata[CMD_W +: VAL_W]);
    assign w_priority = i_s_tdata[CMD_W+VAL_W +: PRI_W];

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(CAPACITY));

    // First match: OR with its negation sets the lowest set bit and all above it
    assign w_found = |w_match;
    assign w_after = w_match | ((~w_match) + CAPACITY'(1));
    assign w_first = w_after & ~{w_after[CAPACITY-2:0], 1'b0};

    // The chain of cells
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic   w_lkeep;
        t_entry w_lent;
        t_entry w_rent;

        assign w_valid[gi] = (r_count > CNT_W'(gi));

        if (gi == 0) begin : g_head
            assign w_lkeep = 1'b1;
            assign w_lent  = w_entry[gi];
        end else begin : g_body
            assign w_lkeep = w_keep[gi-1];
            assign w_lent  = w_entry[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_rent = w_entry[gi];
        end else begin : g_next
            assign w_rent = w_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_valid       (w_valid[gi]),
            .i_shift       (w_shift[gi]),
            .i_left_keep   (w_lkeep),
            .i_left_entry  (w_lent),
            .i_right_entry (w_rent),
            .o_entry       (w_entry[gi]),
            .o_keep        (w_keep[gi]),
            .o_match       (w_match[gi])
        );
    end

    // Select the matching entry for a remove
    always_comb begin
        w_hit = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_first[k]) begin
                w_hit = w_hit | w_entry[k];
            end
        end
    end

    // Decode: chain operation, status, taken pair and new count
    always_comb begin
        w_ctl.op    = OP_NONE;
        w_ctl.value = w_value;
        w_ctl.prio  = w_priority;
        w_shift     = '0;
        w_status    = ST_OK;
        w_tvalue    = '0;
        w_tpri      = '0;
        n_count     = r_count;
        if (w_accept) begin
            unique case (w_cmd)
                CMD_INSERT: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_ctl.op = OP_INSERT;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                CMD_SERVE: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_ctl.op = OP_SHIFT;
                        w_shift  = '1;
                        w_tvalue = w_entry[0].value;
                        w_tpri   = w_entry[0].prio;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                CMD_REMOVE: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else if (!w_found) begin
                        w_status = ST_NOT_FOUND;
                    end else begin
                        w_ctl.op = OP_SHIFT;
                        w_shift  = w_after;
                        w_tvalue = w_hit.value;
                        w_tpri   = w_hit.prio;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                default: w_status = ST_OK;
            endcase
        end
    end

    // Pack the result transaction
    always_comb begin
        n_m_data = '0;
        n_m_data[STAT_W-1:0]                        = w_status;
        n_m_data[STAT_W +: VAL_W]                   = w_tvalue;
        n_m_data[STAT_W+VAL_W +: PRI_W]             = w_tpri;
        n_m_data[STAT_W+VAL_W+PRI_W +: OCNT_W]      = OCNT_W'(n_count);
    end

    // Count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= n_m_data;
        end
    end

endmodule

`default_nettype wire
